// ===== hdl/mscc_pkg.sv =====
package mscc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_LEVELS = 8;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int LVL_W  = 3;
  localparam int LCNT_W = 4;
  localparam int RW_W   = 11;
  localparam int THR_W  = 64;
  localparam int GRAY_W = 8;
  localparam int SUM_W  = 10;
  localparam int PROD_W = 20;

  // Gray is sum/3, done as sum*683 >> 11; exact for every sum up to 765.
  localparam logic [SUM_W-1:0] GRAY_RECIP = SUM_W'(683);
  localparam int               GRAY_SHIFT = 11;

  localparam logic [LCNT_W-1:0] LEVEL_COUNT_RST = LCNT_W'(1);
  localparam logic [RW_W-1:0]   ROW_WIDTH_RST   = RW_W'(MAX_WIDTH);

  localparam logic [3:0] CODE_ALL_ABOVE = 4'hF;
  localparam logic [3:0] CODE_UNIFORM   = 4'h0;

  typedef enum logic [1:0] {
    CFG_LEVEL_COUNT = 2'd0,
    CFG_THRESHOLDS  = 2'd1,
    CFG_ROW_WIDTH   = 2'd2
  } cfg_idx_t;

  function automatic logic [RW_W-1:0] eff_width(input logic [RW_W-1:0] w);
    logic [RW_W-1:0] res;
    res = w;
    if (w < RW_W'(2)) begin
      res = RW_W'(2);
    end else if (w > RW_W'(MAX_WIDTH)) begin
      res = RW_W'(MAX_WIDTH);
    end
    return res;
  endfunction

  function automatic logic [LCNT_W-1:0] eff_levels(input logic [LCNT_W-1:0] n);
    logic [LCNT_W-1:0] res;
    res = n;
    if (n == '0) begin
      res = LCNT_W'(1);
    end else if (n > LCNT_W'(MAX_LEVELS)) begin
      res = LCNT_W'(MAX_LEVELS);
    end
    return res;
  endfunction

endpackage

// ===== hdl/marching_squares_cell_classifier_unit.sv =====
// Marching squares cell classifier.
// Pixels enter in raster order on the in_ channel (valid/ready), one item per
// pixel; in_frame_start marks pixel (0,0) of a frame. Each pixel is reduced to
// gray, the previous row is kept in a 1024-entry line buffer, and every pixel
// with column and row both at least one closes a 2x2 cell. For that cell one
// result item per configured level leaves on the out_ channel, the final one
// with out_last set. Pixels of the first row or first column give no result.
// An accepted pixel passes the input register and the result generator, and
// its first result then lands in the output register. A pixel that closes a
// cell occupies the generator for one result per level (one result per cycle
// while the output register takes it, up to eight); one that closes no cell
// leaves it free. The single result port sets this rate. Input and output
// registers part the two sides, so a new pixel is taken while a result waits.
// When the receiver stalls, the output register holds its item, the generator
// and then the input register fill, and in_ready drops. Reset clears the valid
// flags, position counters and registers to their defaults; the line buffer is
// not cleared and needs no clearing pass. The user must write configuration on
// the cfg_ port only while the block is idle; the block itself does not enforce it.
module marching_squares_cell_classifier_unit
  import mscc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [THR_W-1:0]    cfg_data,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  input  logic                in_frame_start,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [9:0]          out_cell_x,
  output logic [9:0]          out_cell_y,
  output logic [2:0]          out_level,
  output logic [3:0]          out_case_code,
  output logic                out_last
);

  logic [LCNT_W-1:0] level_count_r;
  logic [THR_W-1:0]  thresholds_r;
  logic [RW_W-1:0]   row_width_r;

  logic [GRAY_W-1:0] line_buf [MAX_WIDTH];

  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic [GRAY_W-1:0] left_gray_r;
  logic [GRAY_W-1:0] upper_left_r;

  logic              s1_valid_r;
  logic [7:0]        s1_red_r;
  logic [7:0]        s1_green_r;
  logic [7:0]        s1_blue_r;
  logic [COL_W-1:0]  s1_x_r;
  logic [ROW_W-1:0]  s1_y_r;
  logic [GRAY_W-1:0] s1_ur_r;

  logic              g_valid_r;
  logic [GRAY_W-1:0] g_ul_r;
  logic [GRAY_W-1:0] g_ll_r;
  logic [GRAY_W-1:0] g_ur_r;
  logic [GRAY_W-1:0] g_lr_r;
  logic [COL_W-1:0]  g_cx_r;
  logic [ROW_W-1:0]  g_cy_r;
  logic [LVL_W-1:0]  g_lvl_r;

  logic              out_valid_r;
  logic [9:0]        out_cell_x_r;
  logic [9:0]        out_cell_y_r;
  logic [2:0]        out_level_r;
  logic [3:0]        out_case_code_r;
  logic              out_last_r;

  logic              in_fire;
  logic [RW_W-1:0]   width_eff;
  logic [LCNT_W-1:0] levels_eff;
  logic [COL_W-1:0]  x_cur;
  logic [ROW_W-1:0]  y_cur;
  logic [RW_W-1:0]   x_inc;
  logic [ROW_W:0]    y_inc;

  logic [SUM_W-1:0]  s1_sum;
  logic [PROD_W-1:0] s1_prod;
  logic [GRAY_W-1:0] s1_gray;
  logic              s1_has_cell;
  logic              s1_go;

  logic              out_load;
  logic              g_is_last;
  logic              g_done;
  logic              g_free;
  logic [GRAY_W-1:0] thr;
  logic [3:0]        code_raw;
  logic [3:0]        code;

  assign width_eff  = eff_width(row_width_r);
  assign levels_eff = eff_levels(level_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= LEVEL_COUNT_RST;
      thresholds_r  <= '0;
      row_width_r   <= ROW_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEVEL_COUNT: level_count_r <= cfg_data[LCNT_W-1:0];
        CFG_THRESHOLDS:  thresholds_r  <= cfg_data;
        CFG_ROW_WIDTH:   row_width_r   <= cfg_data[RW_W-1:0];
        default: ;
      endcase
    end
  end

  // Position of the incoming pixel and the counters that follow it.
  always_comb begin
    x_cur = in_frame_start ? '0 : col_r;
    y_cur = in_frame_start ? '0 : row_r;
    if (RW_W'(x_cur) >= width_eff) begin
      x_cur = '0;
    end
    x_inc   = RW_W'(x_cur) + RW_W'(1);
    y_inc   = {1'b0, y_cur} + (ROW_W+1)'(1);
    col_nxt = x_inc[COL_W-1:0];
    row_nxt = y_cur;
    if (x_inc >= width_eff) begin
      col_nxt = '0;
      row_nxt = (y_inc >= (ROW_W+1)'(MAX_HEIGHT)) ? '0 : y_inc[ROW_W-1:0];
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line buffer: read at acceptance, written when the pixel leaves stage one.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ur_r <= line_buf[x_cur];
    end
    if (s1_go) begin
      line_buf[s1_x_r] <= s1_gray;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
      s1_x_r     <= x_cur;
      s1_y_r     <= y_cur;
    end
  end

  assign s1_sum      = SUM_W'(s1_red_r) + SUM_W'(s1_green_r) + SUM_W'(s1_blue_r);
  assign s1_prod     = PROD_W'(s1_sum) * PROD_W'(GRAY_RECIP);
  assign s1_gray     = s1_prod[GRAY_SHIFT +: GRAY_W];
  assign s1_has_cell = (s1_x_r != '0) && (s1_y_r != '0);
  assign s1_go       = s1_valid_r && g_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_gray_r  <= '0;
      upper_left_r <= '0;
    end else if (s1_go) begin
      left_gray_r  <= s1_gray;
      upper_left_r <= s1_ur_r;
    end
  end

  // Result generator: one level per cycle into the output register while it can take one.
  assign out_load  = g_valid_r && (!out_valid_r || out_ready);
  assign g_is_last = (LCNT_W'(g_lvl_r) + LCNT_W'(1)) == levels_eff;
  assign g_done    = out_load && g_is_last;
  assign g_free    = !g_valid_r || g_done;

  assign thr      = thresholds_r[g_lvl_r*GRAY_W +: GRAY_W];
  assign code_raw = {g_ul_r > thr, g_ll_r > thr, g_ur_r > thr, g_lr_r > thr};
  assign code     = (code_raw == CODE_ALL_ABOVE) ? CODE_UNIFORM : code_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
      g_lvl_r   <= '0;
    end else if (s1_go) begin
      g_valid_r <= s1_has_cell;
      g_lvl_r   <= '0;
    end else if (g_done) begin
      g_valid_r <= 1'b0;
    end else if (out_load) begin
      g_lvl_r <= g_lvl_r + LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      g_ul_r <= upper_left_r;
      g_ll_r <= left_gray_r;
      g_ur_r <= s1_ur_r;
      g_lr_r <= s1_gray;
      g_cx_r <= s1_x_r - COL_W'(1);
      g_cy_r <= s1_y_r - ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cell_x_r    <= 10'(g_cx_r);
      out_cell_y_r    <= 10'(g_cy_r);
      out_level_r     <= g_lvl_r;
      out_case_code_r <= code;
      out_last_r      <= g_is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_x    = out_cell_x_r;
  assign out_cell_y    = out_cell_y_r;
  assign out_level     = out_level_r;
  assign out_case_code = out_case_code_r;
  assign out_last      = out_last_r;

endmodule

// ===== tb/mscc_cell_code_checker.sv =====
module mscc_cell_code_checker
  import mscc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [THR_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  logic             in_frame_start,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [9:0]       out_cell_x,
  input  logic [9:0]       out_cell_y,
  input  logic [2:0]       out_level,
  input  logic [3:0]       out_case_code,
  input  logic             out_last,
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    logic [COL_W-1:0] cell_x;
    logic [ROW_W-1:0] cell_y;
    logic [LVL_W-1:0] level;
    logic [3:0]       case_code;
    logic             last;
  } cell_result_t;

  logic [LCNT_W-1:0] level_count_q;
  logic [THR_W-1:0]  thresholds_q;
  logic [RW_W-1:0]   row_width_q;

  logic [GRAY_W-1:0] prev_row_gray [MAX_WIDTH];
  logic [GRAY_W-1:0] left_gray;
  logic [GRAY_W-1:0] upper_left_gray;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;

  cell_result_t expected_cells [$];

  task automatic classify_pixel(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic fs);
    logic [SUM_W-1:0]  sum;
    logic [GRAY_W-1:0] gray;
    logic [GRAY_W-1:0] up_right;
    logic [GRAY_W-1:0] thr;
    logic [RW_W-1:0]   width;
    logic [LCNT_W-1:0] levels;
    logic [COL_W:0]    next_col;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [3:0]        code;
    cell_result_t      exp_res;
    sum = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
    gray = GRAY_W'(sum / 3);
    width = row_width_q;
    if (width < 2) begin
      width = RW_W'(2);
    end else if (width > MAX_WIDTH) begin
      width = RW_W'(MAX_WIDTH);
    end
    if (fs) begin
      column = '0;
      row = '0;
    end
    if (column >= width) begin
      column = '0;
    end
    x = column;
    y = row;
    up_right = prev_row_gray[x];
    if (x != 0 && y != 0) begin
      levels = level_count_q;
      if (levels == 0) begin
        levels = LCNT_W'(1);
      end else if (levels > MAX_LEVELS) begin
        levels = LCNT_W'(MAX_LEVELS);
      end
      for (int k = 0; k < levels; k++) begin
        thr = thresholds_q[8*k +: 8];
        code = {upper_left_gray > thr, left_gray > thr, up_right > thr, gray > thr};
        if (code == CODE_ALL_ABOVE) begin
          code = CODE_UNIFORM;
        end
        exp_res.cell_x = x - COL_W'(1);
        exp_res.cell_y = y - ROW_W'(1);
        exp_res.level = LVL_W'(k);
        exp_res.case_code = code;
        exp_res.last = (k == levels - 1);
        expected_cells.push_back(exp_res);
      end
    end
    upper_left_gray = up_right;
    prev_row_gray[x] = gray;
    left_gray = gray;
    next_col = {1'b0, x} + (COL_W+1)'(1);
    if (next_col >= width) begin
      column = '0;
      if (y == MAX_HEIGHT - 1) begin
        row = '0;
      end else begin
        row = y + ROW_W'(1);
      end
    end else begin
      column = next_col[COL_W-1:0];
    end
  endtask

  task automatic check_result();
    cell_result_t got;
    cell_result_t want;
    got = {out_cell_x, out_cell_y, out_level, out_case_code, out_last};
    if (expected_cells.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected result x=%0d y=%0d level=%0d code=%0d last=%0b",
                 $time, got.cell_x, got.cell_y, got.level, got.case_code, got.last);
      end
    end else begin
      want = expected_cells.pop_front();
      if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
          got.level !== want.level || got.case_code !== want.case_code ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected x=%0d y=%0d level=%0d code=%0d last=%0b",
                   $time, want.cell_x, want.cell_y, want.level, want.case_code,
                   want.last);
          $display("%0t:      got x=%0d y=%0d level=%0d code=%0d last=%0b",
                   $time, got.cell_x, got.cell_y, got.level, got.case_code, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      level_count_q = LEVEL_COUNT_RST;
      thresholds_q = '0;
      row_width_q = ROW_WIDTH_RST;
      left_gray = '0;
      upper_left_gray = '0;
      column = '0;
      row = '0;
      expected_cells.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEVEL_COUNT: level_count_q = cfg_data[LCNT_W-1:0];
          CFG_THRESHOLDS:  thresholds_q = cfg_data;
          CFG_ROW_WIDTH:   row_width_q = cfg_data[RW_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        classify_pixel(in_red, in_green, in_blue, in_frame_start);
      end
      if (out_valid && out_ready) begin
        check_result();
      end
    end
    pending <= expected_cells.size();
  end

endmodule

// ===== tb/tb_marching_squares_cell_classifier_unit.sv =====
module tb_marching_squares_cell_classifier_unit;
  import mscc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam logic [THR_W-1:0] DIRECTED_THRESHOLDS = 64'hC040_FF01_807F_FE00;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [THR_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_red;
  logic [7:0]       in_green;
  logic [7:0]       in_blue;
  logic             in_frame_start;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [9:0]       out_cell_x;
  logic [9:0]       out_cell_y;
  logic [2:0]       out_level;
  logic [3:0]       out_case_code;
  logic             out_last;

  int mismatches;
  int pending;
  int stall_cycles = 0;
  int send_idle_pct = 24;
  int recv_idle_pct = 78;

  marching_squares_cell_classifier_unit dut (.*);

  mscc_cell_code_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles < STALL_LIMIT) begin
      stall_cycles <= stall_cycles + 1;
    end else begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [24:0] directed_pixel(input int i);
    logic [24:0] px;
    case (i)
      0:  px = {1'b1, 24'h000000};
      1:  px = {1'b0, 24'hFFFFFF};
      2:  px = {1'b0, 24'h7F7F7F};
      3:  px = {1'b0, 24'h808080};
      4:  px = {1'b0, 24'hFFFFFE};
      5:  px = {1'b0, 24'h000002};
      6:  px = {1'b0, 24'hFF0080};
      7:  px = {1'b0, 24'h010101};
      8:  px = {1'b0, 24'h808081};
      9:  px = {1'b0, 24'hC0C0C0};
      10: px = {1'b0, 24'h404040};
      11: px = {1'b0, 24'hFEFEFE};
      12: px = {1'b0, 24'hFFFFFF};
      13: px = {1'b0, 24'h000000};
      14: px = {1'b1, 24'h123456};
      15: px = {1'b0, 24'h00FF00};
      16: px = {1'b0, 24'hFF00FF};
      17: px = {1'b0, 24'h0000FF};
      18: px = {1'b0, 24'hFFFFFF};
      19: px = {1'b0, 24'h000000};
      20: px = {1'b1, 24'h7F8081};
      21: px = {1'b1, 24'h010000};
      22: px = {1'b0, 24'hFFFFFF};
      23: px = {1'b0, 24'hFFFFFF};
      default: px = {1'b0, 24'hFF0000};
    endcase
    return px;
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame(input int n_px, input int restart_pct);
    logic fs;
    for (int i = 0; i < n_px; i++) begin
      fs = (i == 0) || ($urandom_range(99) < restart_pct);
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), fs);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [THR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  // The task writes new settings only once every result has drained and the
  // pipeline has had time to retire pixels that close no cell; the block does not enforce this.
  task automatic program_config(input logic [LCNT_W-1:0] levels,
                                input logic [THR_W-1:0] thresholds,
                                input logic [RW_W-1:0] width);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    write_reg(CFG_LEVEL_COUNT, THR_W'(levels));
    write_reg(CFG_THRESHOLDS, thresholds);
    write_reg(CFG_ROW_WIDTH, THR_W'(width));
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int done;
    int width;
    int eff_w;
    int n_px;
    done = 0;
    while (done < n_items) begin
      width = $urandom_range(9);
      if ($urandom_range(7) == 0) begin
        width = $urandom_range(40, 10);
      end
      program_config(LCNT_W'($urandom_range(15)), {$urandom, $urandom}, RW_W'(width));
      eff_w = (width < 2) ? 2 : width;
      n_px = eff_w * $urandom_range(5, 2) + $urandom_range(eff_w - 1);
      if (n_px > n_items - done) begin
        n_px = n_items - done;
      end
      send_frame(n_px, ($urandom_range(3) == 0) ? 5 : 0);
      done += n_px;
    end
  endtask

  initial begin
    logic [24:0] px;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LEVEL_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    in_frame_start = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    program_config(4'd8, DIRECTED_THRESHOLDS, 11'd4);
    for (int i = 0; i < 25; i++) begin
      px = directed_pixel(i);
      send_pixel(px[23:16], px[15:8], px[7:0], px[24]);
    end
    program_config(4'd0, '0, 11'd1);
    send_frame(8, 0);
    program_config(4'd15, '1, 11'd2);
    send_frame(7, 0);
    run_random(75);

    send_idle_pct = 78;
    recv_idle_pct = 24;
    run_random(75);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(75);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
